>>> rtl/hit_or_miss_gap_fill_3x3_core_defines.svh
// Assertion macros shared by the gap fill core.
`ifndef HIT_OR_MISS_GAP_FILL_3X3_CORE_DEFINES_SVH
`define HIT_OR_MISS_GAP_FILL_3X3_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HMGF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HMGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hmgf_pkg.sv
// Types, constants and helpers shared by the gap fill core modules.
package hmgf_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST    = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST   = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    localparam int Q_DEPTH   = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OCNT_W    = $clog2(OUT_DEPTH) + 1;

    // One classified stream step handed from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CFG_W-1:0] col;
        logic [CFG_W-1:0] mcol;
        logic             s1;
        logic             s1_int;
        logic             s2;
        logic             s2_int;
        logic             last;
    } t_op;

    // 3x3 window indexed [row][column], row 0 is the oldest line.
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    function automatic t_win win_shift(t_win w, logic [PIX_W-1:0] top,
                                       logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
        t_win s;
        s = w;
        for (int r = 0; r < 3; r++) begin
            s[r][0] = w[r][1];
            s[r][1] = w[r][2];
        end
        s[0][2] = top;
        s[1][2] = mid;
        s[2][2] = bot;
        return s;
    endfunction

endpackage

>>> rtl/hmgf_fifo.sv
// Small register FIFO used for the step queue and the output buffer.
module hmgf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_push_data,
    output logic                       o_push_ready,
    input  logic                       i_pop,
    output logic                       o_pop_valid,
    output logic [WIDTH-1:0]           o_pop_data,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != (PW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/hmgf_front.sv
// Front end: accepts stream words, tracks frame positions and classifies each step.
module hmgf_front import hmgf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // [7:0] pixel
    input  logic                 i_s_tuser,   // [0] action
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_q_valid,
    output t_op                  o_q_op,
    input  logic                 i_q_ready
);
    localparam logic [CFG_W-1:0] W_RST_EFF =
        (int'(WIDTH_RST) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : WIDTH_RST;

    logic [CFG_W-1:0] r_w_eff, r_w_m1, r_h_eff, r_h_m1;
    logic [CFG_W-1:0] r_in_col, r_in_row, r_out_col, r_out_row;

    logic [CFG_W-1:0] cfg_w, cfg_h, mr, mc;
    logic             accept, flush, complete, c_nz, s1, s2, last;

    assign o_cfg_ready = 1'b1;
    // A register write restarts the frame, so no stream word is taken in that cycle.
    assign o_s_tready  = i_q_ready && !i_cfg_valid;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w = CFG_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            cfg_w = CFG_W'(MAX_WIDTH);
        end else begin
            cfg_w = i_cfg_data;
        end
        if (i_cfg_data == '0) begin
            cfg_h = CFG_W'(1);
        end else if (i_cfg_data > HEIGHT_LIMIT) begin
            cfg_h = HEIGHT_LIMIT;
        end else begin
            cfg_h = i_cfg_data;
        end
    end

    always_comb begin
        accept   = i_s_tvalid && o_s_tready;
        flush    = (i_s_tuser == ACT_FLUSH);
        complete = (r_in_row >= r_h_eff);
        c_nz     = (r_in_col != '0);
        // Position of the stage-one window center relative to this step.
        s1 = (r_in_row >= CFG_W'(2)) || ((r_in_row == CFG_W'(1)) && c_nz);
        mr = c_nz ? (r_in_row - CFG_W'(1)) : (r_in_row - CFG_W'(2));
        mc = c_nz ? (r_in_col - CFG_W'(1)) : r_w_m1;
        s2 = s1 && ((mr >= CFG_W'(2)) || ((mr == CFG_W'(1)) && (mc != '0)));
        last = (r_out_row == r_h_m1) && (r_out_col == r_w_m1);

        o_q_valid       = accept && !(!complete && flush);
        o_q_op.pix      = complete ? '0 : i_s_tdata;
        o_q_op.col      = r_in_col;
        o_q_op.mcol     = mc;
        o_q_op.s1       = s1;
        o_q_op.s1_int   = (mr != '0) && (mr != r_h_m1) && (mc != '0) && (mc != r_w_m1);
        o_q_op.s2       = s2;
        o_q_op.s2_int   = (r_out_row != '0) && (r_out_row != r_h_m1) &&
                          (r_out_col != '0) && (r_out_col != r_w_m1);
        o_q_op.last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff   <= W_RST_EFF;
            r_w_m1    <= W_RST_EFF - CFG_W'(1);
            r_h_eff   <= HEIGHT_RST;
            r_h_m1    <= HEIGHT_RST - CFG_W'(1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_w_eff   <= cfg_w;
                    r_w_m1    <= cfg_w - CFG_W'(1);
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    r_h_eff   <= cfg_h;
                    r_h_m1    <= cfg_h - CFG_W'(1);
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                default: begin
                end
            endcase
        end else if (o_q_valid) begin
            if (s2 && last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_in_col == r_w_m1) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + CFG_W'(1);
                end else begin
                    r_in_col <= r_in_col + CFG_W'(1);
                end
                if (s2) begin
                    if (r_out_col == r_w_m1) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + CFG_W'(1);
                    end else begin
                        r_out_col <= r_out_col + CFG_W'(1);
                    end
                end
            end
        end
    end

endmodule

>>> rtl/hmgf_back.sv
// Back end: line stores, both 3x3 windows and the two hit-or-miss fill stages.
module hmgf_back import hmgf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_op               i_q_op,
    output logic              o_q_pop,
    input  logic [OCNT_W-1:0] i_out_count,
    output logic              o_res_valid,
    output logic [PIX_W-1:0]  o_res_pixel,
    output logic              o_res_last,
    output logic              o_busy
);
    localparam int AW = $clog2(MAX_WIDTH);

    // Each entry holds two rows of one column: [7:0] newer row, [15:8] older row.
    logic [2*PIX_W-1:0] r_in_mem  [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_mid_mem [MAX_WIDTH];

    logic               r_b_valid;
    t_op                r_b_op;
    logic [2*PIX_W-1:0] r_in_rd, r_mid_rd, r_in_fwd_data, r_mid_fwd_data;
    logic               r_in_fwd, r_mid_fwd;
    t_win               r_iw, r_mw;

    t_win               n_iw, n_mw;
    logic [PIX_W-1:0]   a1, b1, a2, b2, mval, res;
    logic [2*PIX_W-1:0] in_wr_data, mid_wr_data;

    // Pop only when the output buffer has room for the step now in flight too.
    assign o_q_pop = i_q_valid &&
                     ((32'(i_out_count) + 32'(r_b_valid)) < 32'(OUT_DEPTH));
    assign o_busy  = r_b_valid;

    always_comb begin
        a1 = r_in_fwd ? r_in_fwd_data[PIX_W-1:0] : r_in_rd[PIX_W-1:0];
        b1 = r_in_fwd ? r_in_fwd_data[2*PIX_W-1:PIX_W] : r_in_rd[2*PIX_W-1:PIX_W];
        in_wr_data = {a1, r_b_op.pix};
        n_iw = win_shift(r_iw, b1, a1, r_b_op.pix);

        mval = n_iw[1][1];
        if (r_b_op.s1_int && (n_iw[1][1] == '0) &&
            (((n_iw[0][0] == PIX_FULL) && (n_iw[2][2] == PIX_FULL)) ||
             ((n_iw[0][2] == PIX_FULL) && (n_iw[2][0] == PIX_FULL)))) begin
            mval = PIX_FULL;
        end

        a2 = r_mid_fwd ? r_mid_fwd_data[PIX_W-1:0] : r_mid_rd[PIX_W-1:0];
        b2 = r_mid_fwd ? r_mid_fwd_data[2*PIX_W-1:PIX_W] : r_mid_rd[2*PIX_W-1:PIX_W];
        mid_wr_data = {a2, mval};
        n_mw = win_shift(r_mw, b2, a2, mval);

        res = n_mw[1][1];
        if (r_b_op.s2_int && (n_mw[1][1] == '0) &&
            (((n_mw[1][0] == PIX_FULL) && (n_mw[1][2] == PIX_FULL)) ||
             ((n_mw[0][1] == PIX_FULL) && (n_mw[2][1] == PIX_FULL)))) begin
            res = PIX_FULL;
        end

        o_res_valid = r_b_valid && r_b_op.s2;
        o_res_pixel = res;
        o_res_last  = r_b_op.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_in_rd  <= r_in_mem[AW'(i_q_op.col)];
            r_mid_rd <= r_mid_mem[AW'(i_q_op.mcol)];
        end
        if (r_b_valid) begin
            r_in_mem[AW'(r_b_op.col)] <= in_wr_data;
        end
        if (r_b_valid && r_b_op.s1) begin
            r_mid_mem[AW'(r_b_op.mcol)] <= mid_wr_data;
        end
    end

    // A read issued while the step ahead writes the same column takes the new word.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_op         <= i_q_op;
            r_in_fwd       <= r_b_valid && (r_b_op.col == i_q_op.col);
            r_in_fwd_data  <= in_wr_data;
            r_mid_fwd      <= r_b_valid && r_b_op.s1 && (r_b_op.mcol == i_q_op.mcol);
            r_mid_fwd_data <= mid_wr_data;
        end
        if (r_b_valid) begin
            r_iw <= n_iw;
        end
        if (r_b_valid && r_b_op.s1) begin
            r_mw <= n_mw;
        end
    end

endmodule

>>> rtl/hit_or_miss_gap_fill_3x3_core.sv
// Top level of the two-stage 3x3 hit-or-miss gap fill core.
//
// Input stream: i_s_tdata carries a pixel, i_s_tuser the action (0 pixel, 1 flush).
// Pixels arrive in raster order; after the last pixel of a frame the source sends
// 2*W + 2 flush words, and the final output word of the frame carries o_m_tlast.
// Output pixel k leaves with the step caused by input position k + 2*W + 2.
// That result word passes from the step queue through the line store read and fill
// stage register into the output buffer before it is offered on the output.
// Throughput is one word per cycle unless the receiver or a register write stalls
// the stream, set by the single-port read and write of each line store per step.
// Configuration writes (index 0 width, 1 height) restart the frame; while a write
// is offered i_s_tready stays low, and writes are meant for an idle core.
// Reset sets width 640 and height 480 and clears all position counters; the
// line stores are not cleared, since stale entries only neighbor border pixels.
// When the receiver stalls, a 4-word output buffer and a 4-step queue absorb the
// words in flight, then i_s_tready drops until the output drains.
`include "hit_or_miss_gap_fill_3x3_core_defines.svh"

module hit_or_miss_gap_fill_3x3_core import hmgf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // [7:0] pixel
    input  logic                 i_s_tuser,   // [0] action
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [PIX_W-1:0]     o_m_tdata,   // [7:0] out_pixel
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic              front_valid, q_ready, q_valid, q_pop;
    t_op               front_op, q_op;
    logic [$bits(t_op)-1:0] q_data;
    logic [$clog2(Q_DEPTH):0] q_count;
    logic [OCNT_W-1:0] out_count;
    logic              res_valid, res_last, out_ready, back_busy;
    logic [PIX_W-1:0]  res_pixel;

    hmgf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_valid   (front_valid),
        .o_q_op      (front_op),
        .i_q_ready   (q_ready)
    );

    hmgf_fifo #(.WIDTH($bits(t_op)), .DEPTH(Q_DEPTH)) u_step_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .i_push_data  (front_op),
        .o_push_ready (q_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .o_count      (q_count)
    );

    assign q_op = t_op'(q_data);

    hmgf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res_pixel (res_pixel),
        .o_res_last  (res_last),
        .o_busy      (back_busy)
    );

    hmgf_fifo #(.WIDTH(PIX_W + 1), .DEPTH(OUT_DEPTH)) u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_push_data  ({res_last, res_pixel}),
        .o_push_ready (out_ready),
        .i_pop        (i_m_tready),
        .o_pop_valid  (o_m_tvalid),
        .o_pop_data   ({o_m_tlast, o_m_tdata}),
        .o_count      (out_count)
    );

    `HMGF_ASSERT_IMPL(a_out_room, i_clk, i_rst_n, res_valid, out_ready, "result word pushed into a full output buffer")
    `HMGF_ASSERT_IMPL(a_credit, i_clk, i_rst_n, 1'b1, (32'(out_count) + 32'(back_busy)) <= 32'(OUT_DEPTH), "output buffer credit exceeded")
    `HMGF_ASSERT_NEXT(a_pop_lands, i_clk, i_rst_n, q_pop, back_busy, "popped step did not reach the fill stages")
    `HMGF_ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, 32'(q_count) <= 32'(Q_DEPTH), "step queue count out of range")

endmodule
